### design/group_by_aggregator_macros.svh
// Assertion macros shared by the group-by aggregator.
`ifndef GROUP_BY_AGGREGATOR_MACROS_SVH
`define GROUP_BY_AGGREGATOR_MACROS_SVH
`define GBA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define GBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

### design/gba_pkg.sv
// ----------------------------------------------------------------------------
// gba_pkg
// Types and constants of the group-by aggregator.
// ----------------------------------------------------------------------------
package gba_pkg;
  localparam int KeyW  = 16;
  localparam int DataW = 32;
  localparam int SumW  = 64;
  localparam int MeanW = 40;

  typedef struct packed {
    logic [KeyW-1:0]         key;
    logic [DataW-1:0]        count;
    logic signed [DataW-1:0] min_e;
    logic signed [DataW-1:0] max_e;
    logic signed [SumW-1:0]  sum;
  } gba_entry_t;
endpackage

### design/gba_if.sv
// ----------------------------------------------------------------------------
// gba_in_if / gba_out_if
// Valid/ready channels of the group-by aggregator.
// ----------------------------------------------------------------------------
interface gba_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] element;
  logic [15:0] group_key;
  logic signed [31:0] item_value;
  logic last_element;
  modport source (output valid, element, group_key, item_value, last_element,
                  input ready);
  modport sink (input valid, element, group_key, item_value, last_element,
                output ready);
endinterface

interface gba_out_if;
  logic valid;
  logic ready;
  logic [15:0] out_key;
  logic [31:0] out_count;
  logic signed [31:0] min_element;
  logic signed [31:0] max_element;
  logic signed [63:0] group_sum;
  logic signed [39:0] group_mean;
  logic last_group;
  logic table_overflow;
  modport source (output valid, out_key, out_count, min_element, max_element,
                  group_sum, group_mean, last_group, table_overflow,
                  input ready);
  modport sink (input valid, out_key, out_count, min_element, max_element,
                group_sum, group_mean, last_group, table_overflow,
                output ready);
endinterface

### design/gba_mean_div.sv
// ----------------------------------------------------------------------------
// gba_mean_div
// Restoring divider: saturated Q8 mean of a 64-bit sum by a 32-bit count.
// ----------------------------------------------------------------------------
module gba_mean_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [63:0]  sum,
  input  logic [31:0]         count,
  output logic                done,
  output logic signed [39:0]  mean
);
  import gba_pkg::*;

  // Dividend is |sum| << 8, 72 bits, one quotient bit per cycle.
  logic [71:0] dvd_r, dvd_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic        neg_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;
  logic [63:0] mag;
  logic [71:0] q;
  logic [39:0] res;

  assign mag = sum[63] ? (~sum + 64'd1) : sum;
  assign trial = {rem_r, dvd_r[71]} - {2'b0, den_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {mag, 8'd0};
      rem_nxt  = '0;
      cnt_nxt  = 7'd72;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        dvd_nxt = {dvd_r[70:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], dvd_r[71]};
        dvd_nxt = {dvd_r[70:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= (count == 32'd0) ? 32'd1 : count;
      neg_r <= sum[63];
    end
  end

  // Saturate the magnitude, then apply the sign.
  assign q = dvd_r;
  always_comb begin
    if (neg_r) begin
      res = (q > 72'h80_0000_0000) ? 40'h80_0000_0000 : q[39:0];
      res = ~res + 40'd1;
    end else begin
      res = (q > 72'h7F_FFFF_FFFF) ? 40'h7F_FFFF_FFFF : q[39:0];
    end
  end

  assign done = done_r;
  assign mean = res;
endmodule

### design/group_by_aggregator.sv
// Timing: a non-closing item is searched and read in S_IDLE, then written back
// in S_UPD. A closing item then emits each group through S_RD, S_DIV and S_OUT;
// in S_DIV the bit-serial mean divider works out the group mean.
// Input is taken only in S_IDLE: a new item waits for write-back and emission.
// Reset: synchronous active-low rst_n empties the table and clears overflow;
// table contents stay undefined until written.
// ----------------------------------------------------------------------------
// group_by_aggregator
// Streaming group-by aggregation with an in-order emission of all stored groups.
// ----------------------------------------------------------------------------
`include "group_by_aggregator_macros.svh"
module group_by_aggregator #(
  parameter int MAX_GROUPS = 16
) (
  input logic clk,
  input logic rst_n,
  gba_in_if.sink    in_ch,
  gba_out_if.source out_ch
);
  import gba_pkg::*;

  localparam int IdxW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CntW = $clog2(MAX_GROUPS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [CntW-1:0] used_r, used_nxt;
  logic            ovf_r, ovf_nxt;
  logic [IdxW-1:0] eidx_r, eidx_nxt;
  logic [CntW-1:0] nemit_r, nemit_nxt;
  logic            ovf_emit_r, ovf_emit_nxt;

  // Keys live in flip-flops for the parallel match; stats in a memory.
  logic [KeyW-1:0] keys_r [MAX_GROUPS];
  gba_entry_t      mem [MAX_GROUPS];
  gba_entry_t      rd_r;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  gba_entry_t      wdata;

  logic signed [DataW-1:0] elem_r;
  logic [KeyW-1:0]         key_r;
  logic signed [DataW-1:0] val_r;
  logic                    last_r;
  logic                    hit_r;
  logic [IdxW-1:0]         hidx_r;

  logic            hit;
  logic [IdxW-1:0] hidx;
  logic            in_acc;
  logic            div_start, div_done;
  logic signed [MeanW-1:0] mean;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    hit  = 1'b0;
    hidx = '0;
    for (int i = MAX_GROUPS - 1; i >= 0; i--) begin
      if (CntW'(i) < used_r && keys_r[i] == in_ch.group_key) begin
        hit  = 1'b1;
        hidx = IdxW'(i);
      end
    end
  end

  assign raddr = (state_r == S_IDLE) ? hidx : eidx_r;

  always_ff @(posedge clk) begin
    rd_r <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    ovf_nxt      = ovf_r;
    eidx_nxt     = eidx_r;
    nemit_nxt    = nemit_r;
    ovf_emit_nxt = ovf_emit_r;
    we           = 1'b0;
    waddr        = hidx_r;
    wdata        = rd_r;
    div_start    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (hit_r) begin
          we = 1'b1;
          if (rd_r.count != '1) wdata.count = rd_r.count + 32'd1;
          if (elem_r < rd_r.min_e) wdata.min_e = elem_r;
          if (elem_r > rd_r.max_e) wdata.max_e = elem_r;
          wdata.sum = rd_r.sum + SumW'(val_r);
        end else if (used_r < CntW'(MAX_GROUPS)) begin
          we          = 1'b1;
          waddr       = used_r[IdxW-1:0];
          wdata.key   = key_r;
          wdata.count = 32'd1;
          wdata.min_e = elem_r;
          wdata.max_e = elem_r;
          wdata.sum   = SumW'(val_r);
          used_nxt    = used_r + CntW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        if (last_r) begin
          nemit_nxt    = used_nxt;
          ovf_emit_nxt = ovf_nxt;
          used_nxt     = '0;
          ovf_nxt      = 1'b0;
          eidx_nxt     = '0;
          state_nxt    = (nemit_nxt == '0) ? S_IDLE : S_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        // The read of entry eidx_r was issued this cycle; start on next.
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!div_done && !out_ch.valid) div_start = 1'b1;
        if (div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (CntW'(eidx_r) + CntW'(1) == nemit_r) begin
            state_nxt = S_IDLE;
          end else begin
            eidx_nxt  = eidx_r + IdxW'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Start pulses once per group: guard with a one-shot flag.
  logic started_r;
  logic div_go;
  assign div_go = div_start && !started_r;

  gba_mean_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .sum   (rd_r.sum),
    .count (rd_r.count),
    .done  (div_done),
    .mean  (mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      used_r     <= '0;
      ovf_r      <= 1'b0;
      eidx_r     <= '0;
      nemit_r    <= '0;
      ovf_emit_r <= 1'b0;
      started_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      ovf_r      <= ovf_nxt;
      eidx_r     <= eidx_nxt;
      nemit_r    <= nemit_nxt;
      ovf_emit_r <= ovf_emit_nxt;
      started_r  <= (state_r == S_DIV);
    end
    if (in_acc) begin
      elem_r <= in_ch.element;
      key_r  <= in_ch.group_key;
      val_r  <= in_ch.item_value;
      last_r <= in_ch.last_element;
      hit_r  <= hit;
      hidx_r <= hidx;
    end
    if (we) keys_r[waddr] <= wdata.key;
  end

  logic signed [MeanW-1:0] mean_r;
  always_ff @(posedge clk) begin
    if (div_done) mean_r <= mean;
  end

  assign out_ch.valid          = (state_r == S_OUT);
  assign out_ch.out_key        = rd_r.key;
  assign out_ch.out_count      = rd_r.count;
  assign out_ch.min_element    = rd_r.min_e;
  assign out_ch.max_element    = rd_r.max_e;
  assign out_ch.group_sum      = rd_r.sum;
  assign out_ch.group_mean     = mean_r;
  assign out_ch.last_group     = (CntW'(eidx_r) + CntW'(1) == nemit_r);
  assign out_ch.table_overflow = ovf_emit_r;

  `GBA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ch.ready,
    "input accepted while busy")
  `GBA_ASSERT_IMPL(a_used_bound, clk, rst_n, 1'b1, used_r <= CntW'(MAX_GROUPS),
    "group count beyond table size")
  `GBA_ASSERT_NEXT(a_emit_clear, clk, rst_n, state_r == S_UPD && last_r,
    used_r == '0 && !ovf_r, "table not cleared after closing item")
endmodule
